[rtl/core/tcw_pkg.sv]
// ============================================================================
// tcw_pkg
// Shared widths, operation codes and character codes of the text console
// writer.
// ============================================================================
package tcw_pkg;

    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int ADDR_W     = 11;
    localparam int OFFSET_W   = 11;
    localparam int CELL_W     = 16;
    localparam int ATTR_W     = 8;

    localparam int S_TDATA_W  = 24;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 32;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [0:0] REG_ATTR = 1'b0;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;
    localparam logic [CHAR_W-1:0] BLANK_CHAR  = 8'h20;

endpackage

[rtl/core/tcw_ram.sv]
// ============================================================================
// tcw_ram
// Character-cell store: one write port and one read port, read data
// registered.
// ============================================================================
module tcw_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [tcw_pkg::CELL_W-1:0]  i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [tcw_pkg::CELL_W-1:0]  o_rdata
);

    logic [tcw_pkg::CELL_W-1:0] r_mem [DEPTH];
    logic [tcw_pkg::CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/tcw_seq.sv]
// ============================================================================
// tcw_seq
// Sequencer: cursor, character decode, scroll and fill sweeps over the
// store, and the result register.
// ============================================================================
module tcw_seq #(
    parameter int COLUMNS  = 80,
    parameter int LINES    = 25,
    parameter int TAB_SIZE = 8,
    parameter int AW       = 11
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [tcw_pkg::ATTR_W-1:0]     i_attr,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [tcw_pkg::OP_W-1:0]       i_op,
    input  logic [tcw_pkg::CHAR_W-1:0]     i_char,
    input  logic [tcw_pkg::ADDR_W-1:0]     i_addr,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [tcw_pkg::OFFSET_W-1:0]   o_offset,
    output logic [tcw_pkg::CELL_W-1:0]     o_cell,
    output logic                           o_scroll,
    output logic                           o_we,
    output logic [AW-1:0]                  o_waddr,
    output logic [tcw_pkg::CELL_W-1:0]     o_wdata,
    output logic                           o_re,
    output logic [AW-1:0]                  o_raddr,
    input  logic [tcw_pkg::CELL_W-1:0]     i_rdata
);

    localparam int CELLS    = LINES * COLUMNS;
    localparam int CW       = $clog2(COLUMNS + 1);
    localparam int LW       = $clog2(LINES);
    localparam int PW       = $clog2(TAB_SIZE);
    localparam int TW       = $clog2(COLUMNS + TAB_SIZE + 1);
    localparam int OW       = AW + 1;
    localparam int XW       = ((AW > tcw_pkg::ADDR_W) ? AW : tcw_pkg::ADDR_W) + 1;
    localparam int FW       = (OW > tcw_pkg::OFFSET_W) ? OW : tcw_pkg::OFFSET_W;
    localparam int COPY_END = (LINES - 1) * COLUMNS;
    localparam int COL_PH   = COLUMNS % TAB_SIZE;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_SCROLL,
        ST_POST,
        ST_DONE
    } t_state;

    t_state                       r_state;
    logic                         r_init;
    logic [AW-1:0]                r_cnt;
    logic [tcw_pkg::CELL_W-1:0]   r_fill_val;
    logic [CW-1:0]                r_col;
    logic [LW-1:0]                r_line;
    logic [PW-1:0]                r_phase;
    logic [tcw_pkg::CHAR_W-1:0]   r_char;
    logic                         r_put_pend;
    logic                         r_scroll;
    logic                         r_is_read;
    logic                         r_rd_ok;
    logic                         r_out_valid;
    logic [tcw_pkg::OFFSET_W-1:0] r_out_offset;
    logic [tcw_pkg::CELL_W-1:0]   r_out_cell;
    logic                         r_out_scroll;

    logic                         accept;
    logic                         is_print;
    logic                         wrap;
    logic                         last_line;
    logic                         rd_ok;
    logic                         need_scroll;
    logic                         direct_write;
    logic [OW-1:0]                line_base;
    logic [OW-1:0]                put_addr;
    logic [OW-1:0]                rd_next;
    logic [TW-1:0]                tab_next;
    logic [XW-1:0]                addr_x;
    logic [FW-1:0]                offset_f;
    logic [tcw_pkg::CELL_W-1:0]   blank;
    logic [PW-1:0]                phase_inc;
    logic [PW-1:0]                phase_dec;
    logic                         out_load;

    assign accept    = i_valid && (r_state == ST_IDLE);
    assign is_print  = (i_char >= tcw_pkg::CH_PRINT_LO) && (i_char <= tcw_pkg::CH_PRINT_HI);
    assign wrap      = (r_col == CW'(COLUMNS));
    assign last_line = (r_line == LW'(LINES - 1));
    assign line_base = OW'(r_line) * OW'(COLUMNS);
    assign put_addr  = wrap ? (line_base + OW'(COLUMNS)) : (line_base + OW'(r_col));
    assign rd_next   = OW'(r_cnt) + OW'(COLUMNS + 1);
    assign tab_next  = TW'(r_col) + TW'(TAB_SIZE) - TW'(r_phase);
    assign addr_x    = XW'(i_addr);
    assign rd_ok     = (addr_x < XW'(CELLS));
    assign offset_f  = FW'(line_base + OW'(r_col));
    assign blank     = {i_attr, tcw_pkg::BLANK_CHAR};
    assign phase_inc = (r_phase == PW'(TAB_SIZE - 1)) ? '0 : r_phase + 1'b1;
    assign phase_dec = (r_phase == '0) ? PW'(TAB_SIZE - 1) : r_phase - 1'b1;
    assign out_load  = (r_state == ST_DONE) && (!r_out_valid || i_ready);

    assign need_scroll = (i_op == tcw_pkg::OP_PUT) && last_line &&
                         ((i_char == tcw_pkg::CH_LF) || (is_print && wrap));
    assign direct_write = (i_op == tcw_pkg::OP_PUT) && is_print && !(wrap && last_line);

    always_comb begin
        o_we    = 1'b0;
        o_waddr = r_cnt;
        o_wdata = r_fill_val;
        o_re    = 1'b0;
        o_raddr = rd_next[AW-1:0];
        unique case (r_state)
            ST_IDLE: begin
                if (accept && direct_write) begin
                    o_we    = 1'b1;
                    o_waddr = put_addr[AW-1:0];
                    o_wdata = {i_attr, i_char};
                end
                if (accept && (i_op == tcw_pkg::OP_READ) && rd_ok) begin
                    o_re    = 1'b1;
                    o_raddr = addr_x[AW-1:0];
                end
                if (accept && need_scroll) begin
                    o_re    = 1'b1;
                    o_raddr = AW'(COLUMNS);
                end
            end
            ST_FILL: begin
                o_we = 1'b1;
            end
            ST_SCROLL: begin
                o_we    = 1'b1;
                o_wdata = (OW'(r_cnt) < OW'(COPY_END)) ? i_rdata : blank;
                o_re    = (rd_next < OW'(CELLS));
            end
            ST_POST: begin
                o_we    = 1'b1;
                o_waddr = AW'(COPY_END);
                o_wdata = {i_attr, r_char};
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_init      <= 1'b1;
            r_cnt       <= '0;
            r_fill_val  <= '0;
            r_col       <= '0;
            r_line      <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state    <= ST_DONE;
                        r_scroll   <= 1'b0;
                        r_is_read  <= 1'b0;
                        r_rd_ok    <= rd_ok;
                        r_char     <= i_char;
                        r_put_pend <= 1'b0;
                        r_cnt      <= '0;
                        unique case (i_op)
                            tcw_pkg::OP_PUT: begin
                                if (i_char == tcw_pkg::CH_BS) begin
                                    if (r_col != '0) begin
                                        r_col   <= r_col - 1'b1;
                                        r_phase <= phase_dec;
                                    end else if (r_line != '0) begin
                                        r_col   <= CW'(COLUMNS);
                                        r_line  <= r_line - 1'b1;
                                        r_phase <= PW'(COL_PH);
                                    end
                                end else if (i_char == tcw_pkg::CH_TAB) begin
                                    if (tab_next >= TW'(COLUMNS)) begin
                                        r_col   <= CW'(COLUMNS);
                                        r_phase <= PW'(COL_PH);
                                    end else begin
                                        r_col   <= tab_next[CW-1:0];
                                        r_phase <= '0;
                                    end
                                end else if (i_char == tcw_pkg::CH_LF) begin
                                    r_col   <= '0;
                                    r_phase <= '0;
                                    if (last_line) begin
                                        r_state  <= ST_SCROLL;
                                        r_scroll <= 1'b1;
                                    end else begin
                                        r_line <= r_line + 1'b1;
                                    end
                                end else if (i_char == tcw_pkg::CH_CR) begin
                                    r_col   <= '0;
                                    r_phase <= '0;
                                end else if (is_print) begin
                                    if (wrap && last_line) begin
                                        r_state    <= ST_SCROLL;
                                        r_scroll   <= 1'b1;
                                        r_put_pend <= 1'b1;
                                    end else if (wrap) begin
                                        r_line  <= r_line + 1'b1;
                                        r_col   <= CW'(1);
                                        r_phase <= PW'(1);
                                    end else begin
                                        r_col   <= r_col + 1'b1;
                                        r_phase <= phase_inc;
                                    end
                                end
                            end
                            tcw_pkg::OP_READ: begin
                                r_is_read <= 1'b1;
                            end
                            tcw_pkg::OP_CLEAR: begin
                                r_state    <= ST_FILL;
                                r_fill_val <= blank;
                                r_col      <= '0;
                                r_line     <= '0;
                                r_phase    <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_FILL: begin
                    if (r_cnt == AW'(CELLS - 1)) begin
                        r_state <= r_init ? ST_IDLE : ST_DONE;
                        r_init  <= 1'b0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_SCROLL: begin
                    if (r_cnt == AW'(CELLS - 1)) begin
                        r_state <= r_put_pend ? ST_POST : ST_DONE;
                        r_col   <= '0;
                        r_phase <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_POST: begin
                    r_state <= ST_DONE;
                    r_col   <= CW'(1);
                    r_phase <= PW'(1);
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_state      <= ST_IDLE;
                        r_out_valid  <= 1'b1;
                        r_out_offset <= offset_f[tcw_pkg::OFFSET_W-1:0];
                        r_out_cell   <= (r_is_read && r_rd_ok) ? i_rdata : '0;
                        r_out_scroll <= r_scroll;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_ready  = (r_state == ST_IDLE);
    assign o_valid  = r_out_valid;
    assign o_offset = r_out_offset;
    assign o_cell   = r_out_cell;
    assign o_scroll = r_out_scroll;

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= CW'(COLUMNS))
        else $error("Cursor column is past the line end.");

    a_line_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line <= LW'(LINES - 1))
        else $error("Cursor line is past the last line.");

    a_scroll_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCROLL) && o_re |-> (o_raddr > o_waddr))
        else $error("Scroll read does not run ahead of the write.");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("Result loaded outside the done state.");

endmodule

[rtl/core/text_console_writer_core.sv]
// ============================================================================
// text_console_writer_core
// Text-mode console engine: a character-cell store with a write cursor,
// driven by put, read and clear requests.
// ============================================================================
// Each request yields one result. A put that scrolls, and a clear, sweep
// every cell of the store through its single write port, which moves one
// cell a cycle; when a printable character lands on the new bottom line,
// the scrolling put writes it after the sweep. After reset a clearing
// pass over all LINES*COLUMNS cells zeroes the store before the first
// request is taken; register writes are taken throughout.
module text_console_writer_core #(
    parameter int COLUMNS  = 80,
    parameter int LINES    = 25,
    parameter int TAB_SIZE = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [7:0] char_code, [18:8] cell_address, [23:19] zero
    input  logic [tcw_pkg::S_TDATA_W-1:0]     s_tdata,
    // [1:0] op
    input  logic [tcw_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [10:0] cursor_offset, [26:11] cell_value, [27] did_scroll, [31:28] zero
    output logic [tcw_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int CELLS = LINES * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    logic [tcw_pkg::ATTR_W-1:0]   r_attr;
    logic                         reg_sel;
    logic [tcw_pkg::OFFSET_W-1:0] out_offset;
    logic [tcw_pkg::CELL_W-1:0]   out_cell;
    logic                         out_scroll;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [tcw_pkg::CELL_W-1:0]   ram_wdata;
    logic                         ram_re;
    logic [AW-1:0]                ram_raddr;
    logic [tcw_pkg::CELL_W-1:0]   ram_rdata;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2:2] == tcw_pkg::REG_ATTR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tcw_pkg::ATTR_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_attr <= pwdata[tcw_pkg::ATTR_W-1:0];
        end
    end

    assign prdata = reg_sel ? tcw_pkg::APB_DATA_W'(r_attr) : '0;

    tcw_seq #(
        .COLUMNS  (COLUMNS),
        .LINES    (LINES),
        .TAB_SIZE (TAB_SIZE),
        .AW       (AW)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_attr   (r_attr),
        .i_valid  (s_tvalid),
        .o_ready  (s_tready),
        .i_op     (s_tuser[1:0]),
        .i_char   (s_tdata[7:0]),
        .i_addr   (s_tdata[18:8]),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_offset (out_offset),
        .o_cell   (out_cell),
        .o_scroll (out_scroll),
        .o_we     (ram_we),
        .o_waddr  (ram_waddr),
        .o_wdata  (ram_wdata),
        .o_re     (ram_re),
        .o_raddr  (ram_raddr),
        .i_rdata  (ram_rdata)
    );

    tcw_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign m_tdata = {4'b0000, out_scroll, out_cell, out_offset};

endmodule

[test/testbench.sv]
// ============================================================================
// testbench
// Self-checking bench for text_console_writer_core. A driver process feeds
// put, read and clear requests from a queue while a monitor process takes
// the results with random back-pressure. Every accepted request runs through
// a behavioral screen model that tracks the cell store, the cursor and the
// attribute register, and each result is compared field by field with the
// oldest prediction. The attribute register is rewritten between phases over
// APB and read back.
// ============================================================================
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCREEN_COLS  = 80;
    localparam int SCREEN_ROWS  = 25;
    localparam int TAB_STEP     = 8;
    localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;

    localparam int      SINK_HOLD_CYCLES = 600;
    localparam int      MAX_REPORTS      = 10;
    localparam longint  WATCHDOG_NS      = 250_000_000;

    localparam logic [tcw_pkg::APB_ADDR_W-1:0] ATTR_ADDR =
        tcw_pkg::APB_ADDR_W'(4 * tcw_pkg::REG_ATTR);
    localparam logic [tcw_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [tcw_pkg::OP_W-1:0]   op;
        logic [tcw_pkg::CHAR_W-1:0] char_code;
        logic [tcw_pkg::ADDR_W-1:0] cell_address;
    } t_console_req;

    typedef struct packed {
        logic                         did_scroll;
        logic [tcw_pkg::CELL_W-1:0]   cell_value;
        logic [tcw_pkg::OFFSET_W-1:0] cursor_offset;
    } t_console_result;

    logic                           i_clk    = 1'b0;
    logic                           i_rst_n  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [tcw_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic [tcw_pkg::S_TUSER_W-1:0]  s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [tcw_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [tcw_pkg::APB_ADDR_W-1:0] paddr    = '0;
    logic [tcw_pkg::APB_DATA_W-1:0] pwdata   = '0;
    logic [tcw_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    text_console_writer_core #(
        .COLUMNS  (SCREEN_COLS),
        .LINES    (SCREEN_ROWS),
        .TAB_SIZE (TAB_STEP)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 i_clk = ~i_clk;

    // Screen model state.
    logic [tcw_pkg::CELL_W-1:0] screen_cells [SCREEN_CELLS];
    int                         cur_line;
    int                         cur_col;
    logic [tcw_pkg::ATTR_W-1:0] attr_shadow = tcw_pkg::ATTR_RESET;

    t_console_req      pending_reqs[$];
    t_console_result   expected_results[$];
    t_console_req      offered_req;
    logic              offer_open    = 1'b0;
    int                send_gap;
    int                sink_wait;
    int                hold_left;
    int                hold_requests = 0;
    int                hold_served   = 0;
    bit                sender_steady = 1'b0;
    bit                sink_steady   = 1'b0;

    int fail_count    = 0;
    int accepted_reqs = 0;
    int seen_results  = 0;
    int read_reqs     = 0;
    int clear_reqs    = 0;
    int scroll_count  = 0;
    int attr_settings = 1;

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    function automatic void shift_screen_up();
        for (int i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLS; i++) begin
            screen_cells[i] = screen_cells[i + SCREEN_COLS];
        end
        for (int i = 0; i < SCREEN_COLS; i++) begin
            screen_cells[(SCREEN_ROWS - 1) * SCREEN_COLS + i] =
                {attr_shadow, tcw_pkg::BLANK_CHAR};
        end
        cur_line = SCREEN_ROWS - 1;
        cur_col  = 0;
    endfunction

    function automatic t_console_result predict_console(input t_console_req rq);
        t_console_result r;
        r = '0;
        case (rq.op)
            tcw_pkg::OP_PUT: begin
                if (rq.char_code == tcw_pkg::CH_BS) begin
                    if (cur_col != 0) begin
                        cur_col--;
                    end else if (cur_line > 0) begin
                        cur_col = SCREEN_COLS;
                        cur_line--;
                    end
                end else if (rq.char_code == tcw_pkg::CH_TAB) begin
                    cur_col = (cur_col / TAB_STEP + 1) * TAB_STEP;
                    if (cur_col > SCREEN_COLS) begin
                        cur_col = SCREEN_COLS;
                    end
                end else if (rq.char_code == tcw_pkg::CH_LF) begin
                    cur_col = 0;
                    cur_line++;
                end else if (rq.char_code == tcw_pkg::CH_CR) begin
                    cur_col = 0;
                end else if (rq.char_code >= tcw_pkg::CH_PRINT_LO &&
                             rq.char_code <= tcw_pkg::CH_PRINT_HI) begin
                    if (cur_col >= SCREEN_COLS) begin
                        cur_col = 0;
                        cur_line++;
                        if (cur_line >= SCREEN_ROWS) begin
                            shift_screen_up();
                            r.did_scroll = 1'b1;
                        end
                    end
                    screen_cells[cur_line * SCREEN_COLS + cur_col] =
                        {attr_shadow, rq.char_code};
                    cur_col++;
                end
                if (cur_line >= SCREEN_ROWS) begin
                    shift_screen_up();
                    r.did_scroll = 1'b1;
                end
            end
            tcw_pkg::OP_READ: begin
                if (rq.cell_address < SCREEN_CELLS) begin
                    r.cell_value = screen_cells[rq.cell_address];
                end
            end
            tcw_pkg::OP_CLEAR: begin
                for (int i = 0; i < SCREEN_CELLS; i++) begin
                    screen_cells[i] = {attr_shadow, tcw_pkg::BLANK_CHAR};
                end
                cur_line = 0;
                cur_col  = 0;
            end
            default: begin
            end
        endcase
        r.cursor_offset = tcw_pkg::OFFSET_W'(cur_line * SCREEN_COLS + cur_col);
        return r;
    endfunction

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            offer_open = s_tvalid;
            if (s_tvalid && s_tready) begin
                expected_results.push_back(predict_console(offered_req));
                accepted_reqs++;
                if (offered_req.op == tcw_pkg::OP_READ) read_reqs++;
                if (offered_req.op == tcw_pkg::OP_CLEAR) clear_reqs++;
                if (expected_results[$].did_scroll) scroll_count++;
                offer_open = 1'b0;
                send_gap = sender_steady ? 0 : $urandom_range(0, 15);
            end
            if (!offer_open) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_reqs.size() != 0) begin
                    offered_req = pending_reqs.pop_front();
                    s_tdata <= {5'b0, offered_req.cell_address, offered_req.char_code};
                    s_tuser <= offered_req.op;
                    offer_open = 1'b1;
                end
            end
            s_tvalid <= offer_open;
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_console_result got;
        t_console_result want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            sink_wait = 0;
            hold_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(t_console_result)-1:0];
                seen_results++;
                if (expected_results.size() == 0) begin
                    report_failure($sformatf(
                        "Result with no request pending: offset %0d cell %h scroll %0d",
                        got.cursor_offset, got.cell_value, got.did_scroll));
                end else begin
                    want = expected_results.pop_front();
                    if (got.cursor_offset !== want.cursor_offset ||
                        got.cell_value !== want.cell_value ||
                        got.did_scroll !== want.did_scroll) begin
                        report_failure($sformatf({"Result %0d mismatch: offset %0d/%0d",
                            " cell %h/%h scroll %0d/%0d (expected/actual)"},
                            seen_results, want.cursor_offset, got.cursor_offset,
                            want.cell_value, got.cell_value, want.did_scroll,
                            got.did_scroll));
                    end
                end
                sink_wait = sink_steady ? 0 : $urandom_range(0, 15);
            end
            if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = SINK_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (sink_wait > 0) begin
                sink_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic t_console_req make_req(input logic [tcw_pkg::OP_W-1:0] op,
                                              input logic [tcw_pkg::CHAR_W-1:0] ch,
                                              input logic [tcw_pkg::ADDR_W-1:0] addr);
        t_console_req rq;
        rq.op           = op;
        rq.char_code    = ch;
        rq.cell_address = addr;
        return rq;
    endfunction

    function automatic t_console_req random_console_request(input int lf_pct);
        int            pick;
        logic [7:0]    ch;
        t_console_req  rq;
        pick = $urandom_range(0, 999);
        rq = make_req(tcw_pkg::OP_PUT,
                      tcw_pkg::CHAR_W'($urandom_range(tcw_pkg::CH_PRINT_LO,
                                                      tcw_pkg::CH_PRINT_HI)),
                      tcw_pkg::ADDR_W'($urandom_range(0, 2047)));
        if (pick < lf_pct * 10) begin
            rq.char_code = tcw_pkg::CH_LF;
        end else if (pick < lf_pct * 10 + 30) begin
            rq.char_code = tcw_pkg::CH_CR;
        end else if (pick < lf_pct * 10 + 70) begin
            rq.char_code = tcw_pkg::CH_TAB;
        end else if (pick < lf_pct * 10 + 110) begin
            rq.char_code = tcw_pkg::CH_BS;
        end else if (pick < lf_pct * 10 + 140) begin
            do begin
                ch = tcw_pkg::CHAR_W'($urandom_range(0, 255));
            end while ((ch >= tcw_pkg::CH_PRINT_LO && ch <= tcw_pkg::CH_PRINT_HI) ||
                       ch == tcw_pkg::CH_BS || ch == tcw_pkg::CH_TAB ||
                       ch == tcw_pkg::CH_LF || ch == tcw_pkg::CH_CR);
            rq.char_code = ch;
        end else if (pick < lf_pct * 10 + 250) begin
            rq.op = tcw_pkg::OP_READ;
            rq.cell_address = ($urandom_range(0, 6) == 0) ?
                              tcw_pkg::ADDR_W'($urandom_range(SCREEN_CELLS, 2047)) :
                              tcw_pkg::ADDR_W'($urandom_range(0, SCREEN_CELLS - 1));
        end else if (pick < lf_pct * 10 + 253) begin
            rq.op = tcw_pkg::OP_CLEAR;
        end else if (pick < lf_pct * 10 + 255) begin
            rq.op = OP_UNUSED;
        end
        return rq;
    endfunction

    task automatic wait_until_drained();
        while (pending_reqs.size() != 0 || offer_open || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic write,
                              input logic [tcw_pkg::APB_DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= ATTR_ADDR;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        if (write) begin
            attr_shadow = data[tcw_pkg::ATTR_W-1:0];
        end else if (prdata !== tcw_pkg::APB_DATA_W'(attr_shadow)) begin
            report_failure($sformatf("Attribute readback mismatch: expected %h actual %h",
                                     tcw_pkg::APB_DATA_W'(attr_shadow), prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_text_phase(input logic [tcw_pkg::ATTR_W-1:0] attr, input int count,
                                  input int lf_pct, input bit steady, input bit hold_sink);
        apb_access(1'b1, tcw_pkg::APB_DATA_W'(attr));
        apb_access(1'b0, '0);
        attr_settings++;
        sender_steady = steady;
        sink_steady   = steady;
        if (hold_sink) begin
            hold_requests++;
        end
        for (int i = 0; i < count; i++) begin
            pending_reqs.push_back(random_console_request(lf_pct));
        end
        wait_until_drained();
    endtask

    initial begin
        for (int i = 0; i < SCREEN_CELLS; i++) begin
            screen_cells[i] = '0;
        end
        cur_line = 0;
        cur_col  = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        apb_access(1'b0, '0);
        pending_reqs.push_back(make_req(tcw_pkg::OP_PUT, tcw_pkg::CH_BS, '0));
        pending_reqs.push_back(make_req(tcw_pkg::OP_READ, 8'h00, 11'd0));
        pending_reqs.push_back(make_req(tcw_pkg::OP_PUT, 8'h41, '0));
        pending_reqs.push_back(make_req(tcw_pkg::OP_PUT, tcw_pkg::CH_PRINT_LO, '0));
        pending_reqs.push_back(make_req(tcw_pkg::OP_PUT, tcw_pkg::CH_PRINT_HI, '0));
        pending_reqs.push_back(make_req(tcw_pkg::OP_PUT, 8'h00, '0));
        pending_reqs.push_back(make_req(tcw_pkg::OP_PUT, 8'h1F, '0));
        pending_reqs.push_back(make_req(tcw_pkg::OP_PUT, 8'h80, '0));
        pending_reqs.push_back(make_req(tcw_pkg::OP_PUT, 8'hFF, '0));
        pending_reqs.push_back(make_req(tcw_pkg::OP_READ, 8'h00, 11'd2));
        pending_reqs.push_back(make_req(tcw_pkg::OP_PUT, tcw_pkg::CH_BS, '0));
        pending_reqs.push_back(make_req(tcw_pkg::OP_PUT, tcw_pkg::CH_TAB, '0));
        pending_reqs.push_back(make_req(tcw_pkg::OP_PUT, tcw_pkg::CH_TAB, '0));
        pending_reqs.push_back(make_req(tcw_pkg::OP_PUT, tcw_pkg::CH_CR, '0));
        pending_reqs.push_back(make_req(tcw_pkg::OP_PUT, tcw_pkg::CH_LF, '0));
        pending_reqs.push_back(make_req(tcw_pkg::OP_PUT, tcw_pkg::CH_BS, '0));
        pending_reqs.push_back(make_req(tcw_pkg::OP_PUT, 8'h5A, '0));
        pending_reqs.push_back(make_req(tcw_pkg::OP_READ, 8'hFF, 11'd80));
        pending_reqs.push_back(make_req(tcw_pkg::OP_READ, 8'h00, 11'd1999));
        pending_reqs.push_back(make_req(tcw_pkg::OP_READ, 8'h00, 11'd2000));
        pending_reqs.push_back(make_req(tcw_pkg::OP_READ, 8'h00, 11'd2047));
        pending_reqs.push_back(make_req(OP_UNUSED, 8'hFF, 11'd2047));
        pending_reqs.push_back(make_req(tcw_pkg::OP_CLEAR, 8'h00, '0));
        pending_reqs.push_back(make_req(tcw_pkg::OP_READ, 8'h00, 11'd1999));
        wait_until_drained();

        run_text_phase(8'h00, 400, 8, 1'b0, 1'b0);
        run_text_phase(8'hFF, 400, 1, 1'b1, 1'b0);
        run_text_phase(tcw_pkg::ATTR_W'($urandom_range(1, 254)), 400, 8, 1'b0, 1'b1);
        run_text_phase(tcw_pkg::ATTR_W'($urandom_range(1, 254)), 400, 3, 1'b0, 1'b0);
        run_text_phase(tcw_pkg::ATTR_RESET, 400, 8, 1'b0, 1'b0);

        repeat (20) @(posedge i_clk);
        $display("Covered %0d requests (%0d reads, %0d clears) with %0d scrolls,",
                 accepted_reqs, read_reqs, clear_reqs, scroll_count);
        $display("under %0d attribute settings, with %0d results checked.",
                 attr_settings, seen_results);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("[text_console_writer_core] OK");
        end else begin
            $display("[text_console_writer_core] ERROR");
        end
        $finish;
    end

    initial begin
        #(WATCHDOG_NS);
        $display("[text_console_writer_core] ERROR");
        $finish;
    end

endmodule

[text_console_writer_core.f]
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/tcw_seq.sv
rtl/core/text_console_writer_core.sv
test/testbench.sv
